>>> src/eased_rect_overshoot_interpolator_unit_defines.svh
// Assertion macros shared by the interpolator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef EASED_RECT_OVERSHOOT_INTERPOLATOR_UNIT_DEFINES_SVH
`define EASED_RECT_OVERSHOOT_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons holds too.
`define EROI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eroi: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define EROI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eroi: next-cycle check failed");

`else

`define EROI_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EROI_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/eroi_pkg.sv
`timescale 1ns / 1ps

package eroi_pkg;

   // Animation constants
   localparam int unsigned DURATION_MS  = 231;
   localparam int unsigned OVERSHOOT_PX = 4;
   localparam int unsigned STRETCH_PX   = 2;

   // Progress scale: 0 .. 2^P_W - 1
   localparam int unsigned P_W        = 16;
   localparam int unsigned PROG_MAX   = (1 << P_W) - 1;
   localparam int unsigned PROG_HALF  = PROG_MAX / 2;
   localparam int unsigned HALF_SHIFT = P_W - 1;
   localparam int unsigned EASE_KNEE  = 1 << HALF_SHIFT;

   // Elapsed time and the reciprocal divide by the duration
   localparam int unsigned DUR_W     = $clog2(DURATION_MS + 1);
   localparam int unsigned NUM_W     = DUR_W + P_W;
   localparam int unsigned RCP_SHIFT = NUM_W;
   localparam longint unsigned RCP_VAL = (64'd1 << RCP_SHIFT) / DURATION_MS;

   // Geometry widths
   localparam int unsigned CFG_W     = 11;
   localparam int unsigned POS_W     = 11;
   localparam int unsigned EXT_W     = 10;
   localparam int unsigned CTR_W     = 13;
   localparam int unsigned LANE_W    = 15;
   localparam int unsigned MAG_W     = LANE_W - 1;
   localparam int unsigned PROD_W    = MAG_W + P_W;
   localparam int unsigned X_W       = 12;
   localparam int unsigned W_W       = 11;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic        [P_W-1:0]     prog_type;
   typedef logic        [2*P_W-1:0]   sq_type;
   typedef logic        [P_W:0]       sqh_type;
   typedef logic        [NUM_W-1:0]   num_type;
   typedef logic        [2*NUM_W-1:0] wide_type;
   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic        [EXT_W-1:0]   ext_type;
   typedef logic signed [CTR_W-1:0]   ctr_type;
   typedef logic signed [LANE_W-1:0]  lane_type;
   typedef logic signed [LANE_W:0]    edge_type;
   typedef logic        [MAG_W-1:0]   mag_type;
   typedef logic        [PROD_W-1:0]  prod_type;
   typedef logic        [PROD_W:0]    prodx_type;
   typedef logic signed [X_W-1:0]     x_type;
   typedef logic        [W_W-1:0]     w_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_X  = 3'd0,
      REG_START_Y  = 3'd1,
      REG_START_W  = 3'd2,
      REG_START_H  = 3'd3,
      REG_TARGET_X = 3'd4,
      REG_TARGET_Y = 3'd5,
      REG_TARGET_W = 3'd6,
      REG_TARGET_H = 3'd7
   } reg_index_type;

   // Operand of the quadratic in-out ease: upper half mirrors around the end
   typedef struct packed {
      logic     hi;
      prog_type m;
   } ease_op_type;

   function automatic ease_op_type ease_operand(input prog_type q);
      ease_op_type op;
      op.hi = (q > prog_type'(EASE_KNEE));
      op.m  = op.hi ? (prog_type'(PROG_MAX) - q) : q;
      return op;
   endfunction

   function automatic prog_type ease_finish(input logic hi, input sq_type sq);
      sqh_type s;
      s = sqh_type'(sq >> HALF_SHIFT);
      return hi ? (prog_type'(PROG_MAX) - prog_type'(s)) : prog_type'(s);
   endfunction

   // x / (2^P_W - 1) for quotients below 2^P_W: (x + (x >> P_W) + 1) >> P_W
   function automatic lane_type div_by_max(input prod_type x);
      prodx_type s;
      s = prodx_type'(x) + prodx_type'(x >> P_W) + prodx_type'(1);
      return lane_type'(s >> P_W);
   endfunction

endpackage

>>> src/eroi_req_if.sv
`timescale 1ns / 1ps

interface eroi_req_if;
   logic               valid;
   logic               ready;
   eroi_pkg::prog_type elapsed_ms;

   modport source (output valid, output elapsed_ms, input ready);
   modport sink   (input valid, input elapsed_ms, output ready);
endinterface

>>> src/eroi_rsp_if.sv
`timescale 1ns / 1ps

interface eroi_rsp_if;
   logic            valid;
   logic            ready;
   eroi_pkg::x_type rect_x;
   eroi_pkg::x_type rect_y;
   eroi_pkg::w_type rect_w;
   eroi_pkg::w_type rect_h;

   modport source (output valid, output rect_x, output rect_y, output rect_w, output rect_h,
                   input ready);
   modport sink   (input valid, input rect_x, input rect_y, input rect_w, input rect_h,
                   output ready);
endinterface

>>> src/eased_rect_overshoot_interpolator_unit.sv
// Eased rectangle interpolator with a directional overshoot.
// req_bus carries one elapsed time per request; rsp_bus returns one rectangle
// (edge x/y, width/height) per request, in request order.
// The csr port writes the start and target rectangles by register index; write
// it only while no request is in flight.
// Throughput: one request per cycle while rsp_bus does not stall. Pipeline stages:
// time scaling (reciprocal multiply and remainder fix-up, 4 stages), two ease
// squarings (3 stages), lane operand select, the lerp multiply, the divide by
// full scale plus add, and the final edge/extent mapping.
// Shape registers feed a 3-stage registered geometry path (centres, dominant
// axis, overshoot point) that settles long before a request reaches it.
// Reset clears the shape registers to zero and empties the pipeline.
// A stall on rsp_bus holds the last stage; earlier stages keep moving into
// empty slots, so req_bus.ready drops only once all 11 stages are full.
`timescale 1ns / 1ps
`include "eased_rect_overshoot_interpolator_unit_defines.svh"

module eased_rect_overshoot_interpolator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [eroi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [eroi_pkg::CFG_W-1:0]          csr_data,
   eroi_req_if.sink                            req_bus,
   eroi_rsp_if.source                          rsp_bus
);

   localparam int STAGES = 11;
   localparam int NL     = 4;   // lanes: dominant centre, dominant extent, other edge, other extent

   typedef struct packed {
      logic                                    past;
      eroi_pkg::num_type                       n;
      eroi_pkg::prog_type                      q0;
      eroi_pkg::num_type                       qd;
      eroi_pkg::prog_type                      total;
      logic                                    second;
      eroi_pkg::ease_op_type                   et_op;
      eroi_pkg::ease_op_type                   ep_op;
      eroi_pkg::prog_type                      phase;
      eroi_pkg::sq_type                        et_sq;
      eroi_pkg::sq_type                        ep_sq;
      eroi_pkg::prog_type                      et;
      eroi_pkg::prog_type                      ep;
      eroi_pkg::lane_type [NL-1:0]             from;
      eroi_pkg::mag_type  [NL-1:0]             mag;
      logic               [NL-1:0]             neg;
      eroi_pkg::prod_type [NL-1:0]             prod;
      eroi_pkg::lane_type [NL-1:0]             val;
      eroi_pkg::x_type                         rx;
      eroi_pkg::x_type                         ry;
      eroi_pkg::w_type                         rw;
      eroi_pkg::w_type                         rh;
   } pipe_type;

   // ---------------------------------------------------------------------
   // Shape registers
   // ---------------------------------------------------------------------
   eroi_pkg::pos_type start_x_ff, start_y_ff, target_x_ff, target_y_ff;
   eroi_pkg::ext_type start_w_ff, start_h_ff, target_w_ff, target_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         start_w_ff  <= '0;
         start_h_ff  <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         target_w_ff <= '0;
         target_h_ff <= '0;
      end else if (csr_we) begin
         unique case (eroi_pkg::reg_index_type'(csr_index))
            eroi_pkg::REG_START_X:  start_x_ff  <= csr_data;
            eroi_pkg::REG_START_Y:  start_y_ff  <= csr_data;
            eroi_pkg::REG_START_W:  start_w_ff  <= csr_data[eroi_pkg::EXT_W-1:0];
            eroi_pkg::REG_START_H:  start_h_ff  <= csr_data[eroi_pkg::EXT_W-1:0];
            eroi_pkg::REG_TARGET_X: target_x_ff <= csr_data;
            eroi_pkg::REG_TARGET_Y: target_y_ff <= csr_data;
            eroi_pkg::REG_TARGET_W: target_w_ff <= csr_data[eroi_pkg::EXT_W-1:0];
            eroi_pkg::REG_TARGET_H: target_h_ff <= csr_data[eroi_pkg::EXT_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Geometry path, three register levels, free running
   // ---------------------------------------------------------------------
   // Level A: doubled centres (2 * edge + extent)
   eroi_pkg::ctr_type ga_fcx_ff, ga_tcx_ff, ga_fcy_ff, ga_tcy_ff;
   eroi_pkg::ctr_type ga_fcx_in, ga_tcx_in, ga_fcy_in, ga_tcy_in;

   assign ga_fcx_in = (eroi_pkg::ctr_type'(start_x_ff) <<< 1) + eroi_pkg::ctr_type'(start_w_ff);
   assign ga_tcx_in = (eroi_pkg::ctr_type'(target_x_ff) <<< 1) + eroi_pkg::ctr_type'(target_w_ff);
   assign ga_fcy_in = (eroi_pkg::ctr_type'(start_y_ff) <<< 1) + eroi_pkg::ctr_type'(start_h_ff);
   assign ga_tcy_in = (eroi_pkg::ctr_type'(target_y_ff) <<< 1) + eroi_pkg::ctr_type'(target_h_ff);

   always_ff @(posedge clock) begin
      ga_fcx_ff <= ga_fcx_in;
      ga_tcx_ff <= ga_tcx_in;
      ga_fcy_ff <= ga_fcy_in;
      ga_tcy_ff <= ga_tcy_in;
   end

   // Level B: pick the dominant axis; ties go vertical
   eroi_pkg::lane_type gb_dx, gb_dy, gb_adx, gb_ady;
   logic               gb_vert_in, gb_vert_ff;
   eroi_pkg::ctr_type  gb_fc_in, gb_tc_in, gb_fc_ff, gb_tc_ff;
   eroi_pkg::ext_type  gb_fe_in, gb_te_in, gb_fe_ff, gb_te_ff;

   always_comb begin
      gb_dx      = eroi_pkg::lane_type'(ga_tcx_ff) - eroi_pkg::lane_type'(ga_fcx_ff);
      gb_dy      = eroi_pkg::lane_type'(ga_tcy_ff) - eroi_pkg::lane_type'(ga_fcy_ff);
      gb_adx     = (gb_dx < 0) ? -gb_dx : gb_dx;
      gb_ady     = (gb_dy < 0) ? -gb_dy : gb_dy;
      gb_vert_in = (gb_ady >= gb_adx);
      gb_fc_in   = gb_vert_in ? ga_fcy_ff : ga_fcx_ff;
      gb_tc_in   = gb_vert_in ? ga_tcy_ff : ga_tcx_ff;
      gb_fe_in   = gb_vert_in ? start_h_ff : start_w_ff;
      gb_te_in   = gb_vert_in ? target_h_ff : target_w_ff;
   end

   always_ff @(posedge clock) begin
      gb_vert_ff <= gb_vert_in;
      gb_fc_ff   <= gb_fc_in;
      gb_tc_ff   <= gb_tc_in;
      gb_fe_ff   <= gb_fe_in;
      gb_te_ff   <= gb_te_in;
   end

   // Level C: overshoot point, stretched extent and per-lane from / delta.
   // Dominant lanes keep both halves: first half heads to the overshoot,
   // second half comes back to the target.
   eroi_pkg::lane_type gc_fc, gc_tc, gc_oc, gc_fe, gc_te, gc_oe;
   eroi_pkg::lane_type gc_from1_in [2], gc_dlt1_in [2], gc_from2_in [2], gc_dlt2_in [2];
   eroi_pkg::lane_type gc_from_o_in [2], gc_dlt_o_in [2];
   eroi_pkg::lane_type gc_from1_ff [2], gc_dlt1_ff [2], gc_from2_ff [2], gc_dlt2_ff [2];
   eroi_pkg::lane_type gc_from_o_ff [2], gc_dlt_o_ff [2];
   logic               gc_vert_ff;

   always_comb begin
      gc_fc = eroi_pkg::lane_type'(gb_fc_ff);
      gc_tc = eroi_pkg::lane_type'(gb_tc_ff);
      gc_fe = eroi_pkg::lane_type'(gb_fe_ff);
      gc_te = eroi_pkg::lane_type'(gb_te_ff);
      priority if (gc_tc > gc_fc) begin
         gc_oc = gc_tc + eroi_pkg::lane_type'(2 * eroi_pkg::OVERSHOOT_PX);
      end else if (gc_tc < gc_fc) begin
         gc_oc = gc_tc - eroi_pkg::lane_type'(2 * eroi_pkg::OVERSHOOT_PX);
      end else begin
         gc_oc = gc_tc;
      end
      gc_oe = gc_te + eroi_pkg::lane_type'(eroi_pkg::STRETCH_PX);

      gc_from1_in[0] = gc_fc;
      gc_dlt1_in[0]  = gc_oc - gc_fc;
      gc_from2_in[0] = gc_oc;
      gc_dlt2_in[0]  = gc_tc - gc_oc;
      gc_from1_in[1] = gc_fe;
      gc_dlt1_in[1]  = gc_oe - gc_fe;
      gc_from2_in[1] = gc_oe;
      gc_dlt2_in[1]  = gc_te - gc_oe;

      // Other axis: plain edge and extent
      if (gb_vert_ff) begin
         gc_from_o_in[0] = eroi_pkg::lane_type'(start_x_ff);
         gc_dlt_o_in[0]  = eroi_pkg::lane_type'(target_x_ff) - eroi_pkg::lane_type'(start_x_ff);
         gc_from_o_in[1] = eroi_pkg::lane_type'(start_w_ff);
         gc_dlt_o_in[1]  = eroi_pkg::lane_type'(target_w_ff) - eroi_pkg::lane_type'(start_w_ff);
      end else begin
         gc_from_o_in[0] = eroi_pkg::lane_type'(start_y_ff);
         gc_dlt_o_in[0]  = eroi_pkg::lane_type'(target_y_ff) - eroi_pkg::lane_type'(start_y_ff);
         gc_from_o_in[1] = eroi_pkg::lane_type'(start_h_ff);
         gc_dlt_o_in[1]  = eroi_pkg::lane_type'(target_h_ff) - eroi_pkg::lane_type'(start_h_ff);
      end
   end

   always_ff @(posedge clock) begin
      gc_vert_ff <= gb_vert_ff;
      for (int j = 0; j < 2; j++) begin
         gc_from1_ff[j]  <= gc_from1_in[j];
         gc_dlt1_ff[j]   <= gc_dlt1_in[j];
         gc_from2_ff[j]  <= gc_from2_in[j];
         gc_dlt2_ff[j]   <= gc_dlt2_in[j];
         gc_from_o_ff[j] <= gc_from_o_in[j];
         gc_dlt_o_ff[j]  <= gc_dlt_o_in[j];
      end
   end

   // ---------------------------------------------------------------------
   // Request pipeline
   // ---------------------------------------------------------------------
   pipe_type          s_ff [1:STAGES];
   pipe_type          s_in [1:STAGES];
   logic [1:STAGES]   vld_ff, vld_in;
   logic [1:STAGES+1] load;

   // A stage takes new contents when it is empty or its contents move on
   always_comb begin
      load[STAGES+1] = rsp_bus.ready;
      for (int k = STAGES; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in[1] = req_bus.valid;
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   logic [eroi_pkg::DUR_W-1:0] st1_t;
   eroi_pkg::wide_type         st2_prod;
   eroi_pkg::num_type          st4_rem;
   eroi_pkg::prog_type         st5_d;
   eroi_pkg::lane_type         st8_dlt [NL];
   eroi_pkg::lane_type         st10_q [NL];
   eroi_pkg::edge_type         st11_diff, st11_edge;
   eroi_pkg::lane_type         st11_cc, st11_ext;

   assign st1_t = req_bus.elapsed_ms[eroi_pkg::DUR_W-1:0];

   always_comb begin
      // Stage 1: flag the finished case, scale time by full progress
      s_in[1]      = '0;
      s_in[1].past = (req_bus.elapsed_ms >= eroi_pkg::prog_type'(eroi_pkg::DURATION_MS));
      s_in[1].n    = (eroi_pkg::num_type'(st1_t) << eroi_pkg::P_W) - eroi_pkg::num_type'(st1_t);

      for (int k = 2; k <= STAGES; k++) begin
         s_in[k] = s_ff[k-1];
      end

      // Stage 2: quotient estimate by reciprocal, low by at most one
      st2_prod     = eroi_pkg::wide_type'(s_ff[1].n) * eroi_pkg::wide_type'(eroi_pkg::RCP_VAL);
      s_in[2].q0   = st2_prod[eroi_pkg::RCP_SHIFT +: eroi_pkg::P_W];

      // Stage 3: back-multiply for the remainder
      s_in[3].qd   = eroi_pkg::num_type'(eroi_pkg::num_type'(s_ff[2].q0)
                                         * eroi_pkg::num_type'(eroi_pkg::DURATION_MS));

      // Stage 4: fix up the quotient
      st4_rem       = s_ff[3].n - s_ff[3].qd;
      s_in[4].total = (st4_rem >= eroi_pkg::num_type'(eroi_pkg::DURATION_MS))
                      ? s_ff[3].q0 + eroi_pkg::prog_type'(1) : s_ff[3].q0;

      // Stage 5: ease operand of total; rescale into the current half
      s_in[5].et_op  = eroi_pkg::ease_operand(s_ff[4].total);
      s_in[5].second = (s_ff[4].total >= eroi_pkg::prog_type'(eroi_pkg::PROG_HALF));
      st5_d          = s_ff[4].total - eroi_pkg::prog_type'(eroi_pkg::PROG_HALF);
      if (s_in[5].second) begin
         s_in[5].phase = eroi_pkg::prog_type'(((eroi_pkg::sq_type'(st5_d) << eroi_pkg::P_W)
                                               - eroi_pkg::sq_type'(st5_d))
                                              >> eroi_pkg::HALF_SHIFT);
      end else begin
         // first half: total * full / half, rounded down, is twice total
         s_in[5].phase = s_ff[4].total << 1;
      end

      // Stage 6: square for total ease; ease operand of phase
      s_in[6].et_sq = eroi_pkg::sq_type'(s_ff[5].et_op.m) * eroi_pkg::sq_type'(s_ff[5].et_op.m);
      s_in[6].ep_op = eroi_pkg::ease_operand(s_ff[5].phase);

      // Stage 7: finish total ease; square for phase ease
      s_in[7].et    = eroi_pkg::ease_finish(s_ff[6].et_op.hi, s_ff[6].et_sq);
      s_in[7].ep_sq = eroi_pkg::sq_type'(s_ff[6].ep_op.m) * eroi_pkg::sq_type'(s_ff[6].ep_op.m);

      // Stage 8: finish phase ease; pick lane operands, split sign and size
      s_in[8].ep = eroi_pkg::ease_finish(s_ff[7].ep_op.hi, s_ff[7].ep_sq);
      for (int j = 0; j < NL; j++) begin
         if (j < 2) begin
            s_in[8].from[j] = s_ff[7].second ? gc_from2_ff[j] : gc_from1_ff[j];
            st8_dlt[j]      = s_ff[7].second ? gc_dlt2_ff[j] : gc_dlt1_ff[j];
         end else begin
            s_in[8].from[j] = gc_from_o_ff[j-2];
            st8_dlt[j]      = gc_dlt_o_ff[j-2];
         end
         s_in[8].neg[j] = (st8_dlt[j] < 0);
         s_in[8].mag[j] = eroi_pkg::mag_type'(s_in[8].neg[j] ? -st8_dlt[j] : st8_dlt[j]);
      end

      // Stage 9: lerp products; dominant lanes use phase ease
      for (int j = 0; j < NL; j++) begin
         s_in[9].prod[j] = eroi_pkg::prod_type'(s_ff[8].mag[j])
                           * eroi_pkg::prod_type'((j < 2) ? s_ff[8].ep : s_ff[8].et);
      end

      // Stage 10: divide by full scale toward zero, add the start point
      for (int j = 0; j < NL; j++) begin
         st10_q[j] = eroi_pkg::div_by_max(s_ff[9].prod[j]);
         s_in[10].val[j] = s_ff[9].neg[j]
                           ? eroi_pkg::lane_type'(s_ff[9].from[j]) - st10_q[j]
                           : eroi_pkg::lane_type'(s_ff[9].from[j]) + st10_q[j];
      end

      // Stage 11: edge from doubled centre and extent; map the axes, or take the target once past
      st11_cc   = eroi_pkg::lane_type'(s_ff[10].val[0]);
      st11_ext  = eroi_pkg::lane_type'(s_ff[10].val[1]);
      st11_diff = eroi_pkg::edge_type'(st11_cc) - eroi_pkg::edge_type'(st11_ext);
      st11_edge = (st11_diff + eroi_pkg::edge_type'(st11_diff[eroi_pkg::LANE_W])) >>> 1;
      if (s_ff[10].past) begin
         s_in[11].rx = eroi_pkg::x_type'(target_x_ff);
         s_in[11].ry = eroi_pkg::x_type'(target_y_ff);
         s_in[11].rw = eroi_pkg::w_type'(target_w_ff);
         s_in[11].rh = eroi_pkg::w_type'(target_h_ff);
      end else if (gc_vert_ff) begin
         s_in[11].rx = eroi_pkg::x_type'(eroi_pkg::lane_type'(s_ff[10].val[2]));
         s_in[11].rw = eroi_pkg::w_type'(eroi_pkg::lane_type'(s_ff[10].val[3]));
         s_in[11].ry = eroi_pkg::x_type'(st11_edge);
         s_in[11].rh = eroi_pkg::w_type'(st11_ext);
      end else begin
         s_in[11].rx = eroi_pkg::x_type'(st11_edge);
         s_in[11].rw = eroi_pkg::w_type'(st11_ext);
         s_in[11].ry = eroi_pkg::x_type'(eroi_pkg::lane_type'(s_ff[10].val[2]));
         s_in[11].rh = eroi_pkg::w_type'(eroi_pkg::lane_type'(s_ff[10].val[3]));
      end
   end

   // Valid bits reset; payload just follows its stage's load
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (load[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= STAGES; k++) begin
         if (load[k]) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign req_bus.ready  = load[1];
   assign rsp_bus.valid  = vld_ff[STAGES];
   assign rsp_bus.rect_x = s_ff[STAGES].rx;
   assign rsp_bus.rect_y = s_ff[STAGES].ry;
   assign rsp_bus.rect_w = s_ff[STAGES].rw;
   assign rsp_bus.rect_h = s_ff[STAGES].rh;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `EROI_ASSERT_NEXT(a_req_enters_pipe, clock, reset, req_bus.valid && req_bus.ready, vld_ff[1])
   `EROI_ASSERT_IMPLY(a_full_stall_blocks, clock, reset, (&vld_ff) && !rsp_bus.ready, !req_bus.ready)
   `EROI_ASSERT_IMPLY(a_quot_estimate, clock, reset, vld_ff[3] && !s_ff[3].past, st4_rem < eroi_pkg::num_type'(2 * eroi_pkg::DURATION_MS))
   `EROI_ASSERT_IMPLY(a_total_range, clock, reset, vld_ff[4] && !s_ff[4].past, s_ff[4].total < eroi_pkg::prog_type'(eroi_pkg::PROG_MAX))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import eroi_pkg::*;

   // Arithmetic of the interpolator, kept in plain ints
   localparam int FULL_SCALE  = 65535;
   localparam int HALF_SCALE  = FULL_SCALE / 2;
   localparam int EASE_KNEE_Q = 32768;
   localparam int EASE_SHIFT  = 15;
   localparam int DUR         = int'(DURATION_MS);
   localparam int OVERSHOOT   = int'(OVERSHOOT_PX);
   localparam int STRETCH     = int'(STRETCH_PX);

   // Run control
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 170;
   localparam int HOLD_CYCLES   = 120;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      pos_type sx;
      pos_type sy;
      ext_type sw;
      ext_type sh;
      pos_type tx;
      pos_type ty;
      ext_type tw;
      ext_type th;
   } shape_t;

   typedef struct {
      x_type x;
      x_type y;
      w_type w;
      w_type h;
   } rect_t;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   eroi_req_if req_bus ();
   eroi_rsp_if rsp_bus ();

   eased_rect_overshoot_interpolator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   shape_t      shape;
   rect_t       pending_rects[$];
   rect_t       want;
   int          mismatch_count = 0;
   int          burst_left = 0;
   int          cycle_count = 0;
   int          hold_asked = 0;
   int          hold_taken = 0;
   int          hold_left = 0;
   logic [31:0] stall_tick = '0;

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int clamp_prog(input int p);
      if (p <= 0) return 0;
      if (p >= FULL_SCALE) return FULL_SCALE;
      return p;
   endfunction

   // Quadratic in-out ease; the upper half mirrors around full scale
   function automatic int ease_quad(input int p);
      longint q;
      longint r;
      q = clamp_prog(p);
      if (q <= EASE_KNEE_Q) return int'((q * q) >>> EASE_SHIFT);
      r = FULL_SCALE - q;
      return FULL_SCALE - int'((r * r) >>> EASE_SHIFT);
   endfunction

   // Stretch the progress window lo..hi back onto 0..full scale
   function automatic int rescale_window(input int p, input int lo, input int hi);
      int c;
      c = clamp_prog(p);
      if (c <= lo) return 0;
      if (c >= hi) return FULL_SCALE;
      return int'((longint'(c - lo) * FULL_SCALE) / (hi - lo));
   endfunction

   // Signed divide truncates toward zero, matching the block
   function automatic int lerp_px(input int p, input int from_px, input int to_px);
      return from_px + int'((longint'(to_px - from_px) * p) / FULL_SCALE);
   endfunction

   function automatic rect_t predict_rect(input prog_type t);
      rect_t  r;
      int     total, et, phase, ep;
      int     sx, sy, sw, sh, tx, ty, tw, th;
      int     fcx, tcx, fcy, tcy, dcx, dcy;
      int     fc, tc, fe, te, dir, oc, cc, oe, ext, edge_px;
      int     rx, ry, rw, rh;
      bit     second, vertical;
      sx = int'(shape.sx);
      sy = int'(shape.sy);
      sw = int'(shape.sw);
      sh = int'(shape.sh);
      tx = int'(shape.tx);
      ty = int'(shape.ty);
      tw = int'(shape.tw);
      th = int'(shape.th);
      if (int'(t) >= DUR) begin
         rx = tx;
         ry = ty;
         rw = tw;
         rh = th;
      end else begin
         total  = int'((longint'(t) * FULL_SCALE) / DUR);
         et     = ease_quad(total);
         second = (total >= HALF_SCALE);
         phase  = second ? rescale_window(total, HALF_SCALE, FULL_SCALE)
                         : rescale_window(total, 0, HALF_SCALE);
         ep     = ease_quad(phase);

         // Doubled centres keep the half pixel of odd extents
         fcx = sx * 2 + sw;
         tcx = tx * 2 + tw;
         fcy = sy * 2 + sh;
         tcy = ty * 2 + th;
         dcx = (tcx > fcx) ? tcx - fcx : fcx - tcx;
         dcy = (tcy > fcy) ? tcy - fcy : fcy - tcy;
         vertical = (dcy >= dcx);

         fc = vertical ? fcy : fcx;
         tc = vertical ? tcy : tcx;
         fe = vertical ? sh : sw;
         te = vertical ? th : tw;

         dir = (tc > fc) ? 1 : ((tc < fc) ? -1 : 0);
         oc  = tc + dir * OVERSHOOT * 2;
         cc  = second ? lerp_px(ep, oc, tc) : lerp_px(ep, fc, oc);
         oe  = te + STRETCH;
         ext = second ? lerp_px(ep, oe, te) : lerp_px(ep, fe, oe);
         edge_px = (cc - ext) / 2;

         if (vertical) begin
            rx = lerp_px(et, sx, tx);
            rw = lerp_px(et, sw, tw);
            ry = edge_px;
            rh = ext;
         end else begin
            rx = edge_px;
            rw = ext;
            ry = lerp_px(et, sy, ty);
            rh = lerp_px(et, sh, th);
         end
      end
      r.x = x_type'(rx);
      r.y = x_type'(ry);
      r.w = w_type'(rw);
      r.h = w_type'(rh);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Register writes
   // ---------------------------------------------------------------------

   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      // Widths and heights keep only their low 10 bits
      case (idx)
         REG_START_X:  shape.sx = pos_type'(data);
         REG_START_Y:  shape.sy = pos_type'(data);
         REG_START_W:  shape.sw = ext_type'(data);
         REG_START_H:  shape.sh = ext_type'(data);
         REG_TARGET_X: shape.tx = pos_type'(data);
         REG_TARGET_Y: shape.ty = pos_type'(data);
         REG_TARGET_W: shape.tw = ext_type'(data);
         REG_TARGET_H: shape.th = ext_type'(data);
         default: ;
      endcase
   endtask

   // Call only with nothing in flight
   task automatic load_shape(input int sx, input int sy, input int sw, input int sh,
                             input int tx, input int ty, input int tw, input int th);
      write_reg(REG_START_X,  11'(sx));
      write_reg(REG_START_Y,  11'(sy));
      write_reg(REG_START_W,  11'(sw));
      write_reg(REG_START_H,  11'(sh));
      write_reg(REG_TARGET_X, 11'(tx));
      write_reg(REG_TARGET_Y, 11'(ty));
      write_reg(REG_TARGET_W, 11'(tw));
      write_reg(REG_TARGET_H, 11'(th));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one elapsed time; bursts of random length with random gaps between
   task automatic send_request(input prog_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         // leave some bursts back to back so stretches run without idling
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 13);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.elapsed_ms <= t;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_rects.push_back(predict_rect(t));
   endtask

   // Drop valid and hold until every expected rectangle has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_rects.size() != 0) @(posedge clock);
   endtask

   // Mostly times inside the animation, the rest across the full 16-bit range
   function automatic prog_type rand_time();
      case ($urandom_range(0, 9))
         0, 1:    return prog_type'($urandom_range(0, 65535));
         2:       return prog_type'($urandom_range(DUR - 3, DUR + 3));
         3:       return prog_type'($urandom_range(110, 122));
         default: return prog_type'($urandom_range(0, DUR - 1));
      endcase
   endfunction

   function automatic int rand_pos();
      case ($urandom_range(0, 7))
         0:       return -1024;
         1:       return 1023;
         default: return $urandom_range(0, 2047) - 1024;
      endcase
   endfunction

   // Bit 10 of an extent write is random; the block must ignore it
   function automatic int rand_ext();
      int v;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = 1023;
         default: v = $urandom_range(0, 1023);
      endcase
      return v + ($urandom_range(0, 1) * 1024);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Shapes clear to zero on reset: no motion, the extent still stretches
   task automatic test_reset_shape();
      send_request(16'd0);
      send_request(16'd150);
      wait_drained();
   endtask

   // Each dominant-axis case, including a tie that must go vertical
   task automatic test_axis_choice();
      int cfg;
      for (cfg = 0; cfg < 5; cfg++) begin
         case (cfg)
            0: load_shape(0, 0, 40, 20, 10, 300, 60, 30);           // down
            1: load_shape(0, 500, 100, 100, 0, -600, 80, 40);       // up
            2: load_shape(-500, 0, 20, 20, 700, 10, 200, 50);       // right
            3: load_shape(800, -20, 30, 30, -900, 40, 10, 10);      // left
            default: load_shape(0, 0, 10, 10, 50, 50, 10, 10);      // tie
         endcase
         send_request(16'd40);
         send_request(16'd116);
         send_request(16'd200);
         wait_drained();
      end
   endtask

   // Time boundaries: start, the switch into the return half, end, saturation
   task automatic test_time_edges();
      load_shape(-37, 120, 64, 15, 210, -333, 17, 301);
      send_request(16'd0);
      send_request(16'd1);
      send_request(16'd115);
      send_request(16'd116);
      send_request(16'd230);
      send_request(prog_type'(DUR));
      send_request(prog_type'(DUR + 1));
      send_request(16'hFFFF);
      wait_drained();
   endtask

   // Random times over several shapes, opening with the extreme corners
   task automatic test_random_phases();
      int phase;
      int i;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: load_shape(-1024, -1024, 0, 0, 1023, 1023, 1023, 1023);
            1: load_shape(1023, 1023, 2047, 2047, -1024, -1024, 1024, 1024);
            2: load_shape(-1024, 1023, 1023, 0, 1023, -1024, 0, 1023);
            default: load_shape(rand_pos(), rand_pos(), rand_ext(), rand_ext(),
                                rand_pos(), rand_pos(), rand_ext(), rand_ext());
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) send_request(rand_time());
         wait_drained();
      end
   endtask

   // Receiver holds off while requests keep coming, so the pipeline fills
   task automatic test_backpressure();
      int i;
      load_shape(rand_pos(), rand_pos(), rand_ext(), rand_ext(),
                 rand_pos(), rand_pos(), rand_ext(), rand_ext());
      hold_asked++;
      for (i = 0; i < 60; i++) send_request(rand_time());
      wait_drained();
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      req_bus.valid      = 1'b0;
      req_bus.elapsed_ms = '0;
      rsp_bus.ready      = 1'b0;
      shape              = '{default: '0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_shape();
      test_axis_choice();
      test_time_edges();
      test_backpressure();
      test_random_phases();

      // Let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Stall on a pattern picked by bits 7:6 of a tick counter; a requested hold-off wins
   always @(negedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      stall_tick = stall_tick + 1;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_tick[7:6])
            2'd0:    rsp_bus.ready <= 1'b1;
            2'd1:    rsp_bus.ready <= 1'($urandom_range(0, 1));
            2'd2:    rsp_bus.ready <= (stall_tick[1:0] == 2'd0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Compare each accepted rectangle with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rects.size() == 0) begin
            $error("rectangle with no request pending: x=%0d y=%0d w=%0d h=%0d",
                   rsp_bus.rect_x, rsp_bus.rect_y, rsp_bus.rect_w, rsp_bus.rect_h);
            mismatch_count++;
         end else begin
            want = pending_rects.pop_front();
            if (rsp_bus.rect_x !== want.x) begin
               $error("rect_x: expected %0d, got %0d", want.x, rsp_bus.rect_x);
               mismatch_count++;
            end
            if (rsp_bus.rect_y !== want.y) begin
               $error("rect_y: expected %0d, got %0d", want.y, rsp_bus.rect_y);
               mismatch_count++;
            end
            if (rsp_bus.rect_w !== want.w) begin
               $error("rect_w: expected %0d, got %0d", want.w, rsp_bus.rect_w);
               mismatch_count++;
            end
            if (rsp_bus.rect_h !== want.h) begin
               $error("rect_h: expected %0d, got %0d", want.h, rsp_bus.rect_h);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

>>> files.f
+incdir+src
src/eroi_pkg.sv
src/eroi_req_if.sv
src/eroi_rsp_if.sv
src/eased_rect_overshoot_interpolator_unit.sv
tb/sv/tb.sv
